FILE: rtl/core/triangle_tangent_frame_defines.svh
// assertion macros for the triangle tangent frame block
`ifndef TRIANGLE_TANGENT_FRAME_DEFINES_SVH
`define TRIANGLE_TANGENT_FRAME_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TTF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TTF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TTF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/ttf_pkg.sv
// shared types and constants of the triangle tangent frame block
`default_nettype none
package ttf_pkg;
    localparam int FRAC_BITS = 16;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
        logic               end_of_list;
    } t_in;

    typedef struct packed {
        logic signed [31:0] tangent_x;
        logic signed [31:0] tangent_y;
        logic signed [31:0] tangent_z;
        logic signed [31:0] bitangent_x;
        logic signed [31:0] bitangent_y;
        logic signed [31:0] bitangent_z;
        logic               degenerate;
    } t_out;

    // product selector for the shared multiplier
    typedef enum logic [3:0] {
        M_DET_A, M_DET_B,
        M_T0_A, M_T0_B, M_T1_A, M_T1_B, M_T2_A, M_T2_B,
        M_B0_A, M_B0_B, M_B1_A, M_B1_B, M_B2_A, M_B2_B
    } t_msel;

    typedef struct packed {
        logic  load_first;
        logic  load_second;
        logic  load_third;
        logic  mul_en;
        t_msel msel;
        logic  div_start;
        logic  [2:0] div_idx;
        logic  emit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic det_zero;
    } t_stat;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        if (v > 33'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -33'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] subsat64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [64:0] d;
        d = {a[63], a} - {b[63], b};
        if (d[64] != d[63]) begin
            return d[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return d[63:0];
    endfunction
endpackage
`default_nettype wire

FILE: rtl/core/ttf_div.sv
// iterative restoring divider: truncating (n << FRAC_BITS) / d, signed, saturated to 32 bits
`default_nettype none
module ttf_div (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire signed [63:0] i_num,
    input  wire signed [63:0] i_den,
    output logic              o_done,
    output logic signed [31:0] o_quot
);
    localparam int NBITS = 64 + ttf_pkg::FRAC_BITS;

    logic [NBITS-1:0] r_dividend, n_dividend;
    logic [63:0]      r_rem, n_rem;
    logic [63:0]      r_den;
    logic [32:0]      r_q, n_q;
    logic             r_big, n_big;
    logic             r_neg;
    logic             r_busy;
    logic [6:0]       r_cnt;
    logic [64:0]      w_shift;
    logic             w_qbit;
    logic [63:0]      w_nmag;
    logic [63:0]      w_dmag;

    assign w_nmag  = i_num[63] ? 64'd0 - i_num : i_num;
    assign w_dmag  = i_den[63] ? 64'd0 - i_den : i_den;
    assign w_shift = {r_rem, r_dividend[NBITS-1]};
    assign w_qbit  = w_shift >= {1'b0, r_den};

    always_comb begin
        // remainder stays below the divisor, so it always fits 64 bits
        n_rem      = w_qbit ? 64'(w_shift - {1'b0, r_den}) : w_shift[63:0];
        n_dividend = {r_dividend[NBITS-2:0], 1'b0};
        n_q        = r_q;
        n_big      = r_big;
        if (!r_big) begin
            n_q = {r_q[31:0], w_qbit};
            if (r_q[32] || r_q[31]) begin
                n_big = r_q[31] ? 1'b1 : r_big;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy     <= 1'b1;
                r_cnt      <= 7'(NBITS - 1);
                r_dividend <= {w_nmag, {ttf_pkg::FRAC_BITS{1'b0}}};
                r_den      <= w_dmag;
                r_rem      <= '0;
                r_q        <= '0;
                r_big      <= 1'b0;
                r_neg      <= i_num[63] ^ i_den[63];
            end else if (r_busy) begin
                r_rem      <= n_rem;
                r_dividend <= n_dividend;
                r_q        <= n_q;
                r_big      <= n_big || n_q[32];
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
                r_cnt <= r_cnt - 7'd1;
            end
        end
    end

    always_comb begin
        if (r_neg) begin
            if (r_big || r_q[32] || (r_q[31] && r_q[30:0] != '0)) begin
                o_quot = 32'sh80000000;
            end else begin
                o_quot = 32'(-$signed({1'b0, r_q[31:0]}));
            end
        end else begin
            if (r_big || r_q[32] || r_q[31]) begin
                o_quot = 32'sh7fffffff;
            end else begin
                o_quot = $signed(r_q[31:0]);
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/ttf_datapath.sv
// datapath: vertex store, deltas, shared multiplier, numerators and divider
`default_nettype none
module ttf_datapath (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  ttf_pkg::t_in    i_vtx,
    input  ttf_pkg::t_cmd   i_cmd,
    output ttf_pkg::t_stat  o_stat,
    output ttf_pkg::t_out   o_res,
    output logic            o_strobe
);
    logic signed [31:0] r_p0 [3];
    logic signed [31:0] r_p1 [3];
    logic signed [31:0] r_uv0 [2];
    logic signed [31:0] r_uv1 [2];
    logic signed [31:0] r_dp1 [3];
    logic signed [31:0] r_dp2 [3];
    logic signed [31:0] r_du1, r_dv1, r_du2, r_dv2;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_hold;
    logic signed [63:0] r_det;
    logic signed [63:0] r_num [6];
    logic signed [31:0] r_q [6];
    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_diff;
    logic               r_deg;
    logic               r_step;
    ttf_pkg::t_msel     r_msel;
    logic signed [31:0] w_quot;
    logic               w_done;

    always_comb begin
        case (i_cmd.msel)
            ttf_pkg::M_DET_A: begin w_ma = r_du1;    w_mb = r_dv2; end
            ttf_pkg::M_DET_B: begin w_ma = r_dv1;    w_mb = r_du2; end
            ttf_pkg::M_T0_A:  begin w_ma = r_dp1[0]; w_mb = r_dv2; end
            ttf_pkg::M_T0_B:  begin w_ma = r_dp2[0]; w_mb = r_dv1; end
            ttf_pkg::M_T1_A:  begin w_ma = r_dp1[1]; w_mb = r_dv2; end
            ttf_pkg::M_T1_B:  begin w_ma = r_dp2[1]; w_mb = r_dv1; end
            ttf_pkg::M_T2_A:  begin w_ma = r_dp1[2]; w_mb = r_dv2; end
            ttf_pkg::M_T2_B:  begin w_ma = r_dp2[2]; w_mb = r_dv1; end
            ttf_pkg::M_B0_A:  begin w_ma = r_dp2[0]; w_mb = r_du1; end
            ttf_pkg::M_B0_B:  begin w_ma = r_dp1[0]; w_mb = r_du2; end
            ttf_pkg::M_B1_A:  begin w_ma = r_dp2[1]; w_mb = r_du1; end
            ttf_pkg::M_B1_B:  begin w_ma = r_dp1[1]; w_mb = r_du2; end
            ttf_pkg::M_B2_A:  begin w_ma = r_dp2[2]; w_mb = r_du1; end
            ttf_pkg::M_B2_B:  begin w_ma = r_dp1[2]; w_mb = r_du2; end
            default:          begin w_ma = '0;       w_mb = '0;    end
        endcase
    end

    assign w_diff = ttf_pkg::subsat64(r_hold, r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_p0[i] <= '0;
                r_p1[i] <= '0;
            end
            for (int i = 0; i < 2; i++) begin
                r_uv0[i] <= '0;
                r_uv1[i] <= '0;
            end
            r_step   <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_cmd.emit;
            if (i_cmd.load_first) begin
                r_p0[0] <= i_vtx.pos_x; r_p0[1] <= i_vtx.pos_y; r_p0[2] <= i_vtx.pos_z;
                r_uv0[0] <= i_vtx.tex_u; r_uv0[1] <= i_vtx.tex_v;
            end
            if (i_cmd.load_second) begin
                r_p1[0] <= i_vtx.pos_x; r_p1[1] <= i_vtx.pos_y; r_p1[2] <= i_vtx.pos_z;
                r_uv1[0] <= i_vtx.tex_u; r_uv1[1] <= i_vtx.tex_v;
            end
            // product is registered in the cycle after issue; second of a pair finishes a difference
            r_step <= i_cmd.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_third) begin
            r_dp1[0] <= ttf_pkg::sat32(33'(r_p1[0]) - 33'(r_p0[0]));
            r_dp1[1] <= ttf_pkg::sat32(33'(r_p1[1]) - 33'(r_p0[1]));
            r_dp1[2] <= ttf_pkg::sat32(33'(r_p1[2]) - 33'(r_p0[2]));
            r_dp2[0] <= ttf_pkg::sat32(33'(i_vtx.pos_x) - 33'(r_p0[0]));
            r_dp2[1] <= ttf_pkg::sat32(33'(i_vtx.pos_y) - 33'(r_p0[1]));
            r_dp2[2] <= ttf_pkg::sat32(33'(i_vtx.pos_z) - 33'(r_p0[2]));
            r_du1 <= ttf_pkg::sat32(33'(r_uv1[0]) - 33'(r_uv0[0]));
            r_dv1 <= ttf_pkg::sat32(33'(r_uv1[1]) - 33'(r_uv0[1]));
            r_du2 <= ttf_pkg::sat32(33'(i_vtx.tex_u) - 33'(r_uv0[0]));
            r_dv2 <= ttf_pkg::sat32(33'(i_vtx.tex_v) - 33'(r_uv0[1]));
        end
        if (i_cmd.mul_en) begin
            r_prod <= 64'(w_ma) * 64'(w_mb);
            r_msel <= i_cmd.msel;
        end
        if (r_step) begin
            r_hold <= r_prod;
            case (r_msel)
                ttf_pkg::M_DET_B: r_det    <= w_diff;
                ttf_pkg::M_T0_B:  r_num[0] <= w_diff;
                ttf_pkg::M_T1_B:  r_num[1] <= w_diff;
                ttf_pkg::M_T2_B:  r_num[2] <= w_diff;
                ttf_pkg::M_B0_B:  r_num[3] <= w_diff;
                ttf_pkg::M_B1_B:  r_num[4] <= w_diff;
                ttf_pkg::M_B2_B:  r_num[5] <= w_diff;
                default: ;
            endcase
        end
        if (w_done) begin
            r_q[i_cmd.div_idx] <= w_quot;
        end
        if (i_cmd.emit) begin
            r_deg <= (r_det == '0);
        end
    end

    ttf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num[i_cmd.div_idx]),
        .i_den   (r_det),
        .o_done  (w_done),
        .o_quot  (w_quot)
    );

    assign o_stat.div_done = w_done;
    assign o_stat.det_zero = (r_det == '0);

    always_comb begin
        o_res.degenerate  = r_deg;
        o_res.tangent_x   = r_deg ? '0 : r_q[0];
        o_res.tangent_y   = r_deg ? '0 : r_q[1];
        o_res.tangent_z   = r_deg ? '0 : r_q[2];
        o_res.bitangent_x = r_deg ? '0 : r_q[3];
        o_res.bitangent_y = r_deg ? '0 : r_q[4];
        o_res.bitangent_z = r_deg ? '0 : r_q[5];
    end
endmodule
`default_nettype wire

FILE: rtl/core/ttf_ctrl.sv
// controller: vertex phase, multiply sequence, divide sequence and result emit
`default_nettype none
module ttf_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_accept,
    input  wire            i_last,
    input  ttf_pkg::t_stat i_stat,
    output ttf_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic [1:0]     o_phase
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic [3:0] r_mcnt, n_mcnt;
    logic [2:0] r_didx, n_didx;
    logic       r_dgo, n_dgo;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_mcnt  = r_mcnt;
        n_didx  = r_didx;
        n_dgo   = 1'b0;
        o_cmd   = '0;
        o_cmd.msel    = ttf_pkg::t_msel'(r_mcnt);
        o_cmd.div_idx = r_didx;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    case (r_phase)
                        2'd1: begin
                            o_cmd.load_second = 1'b1;
                            n_phase = 2'd2;
                        end
                        2'd2: begin
                            o_cmd.load_third = 1'b1;
                            n_phase = 2'd0;
                            n_state = S_MUL;
                            n_mcnt  = '0;
                        end
                        default: begin
                            o_cmd.load_first = 1'b1;
                            n_phase = 2'd1;
                        end
                    endcase
                    if (i_last) begin
                        n_phase = 2'd0;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_mcnt = r_mcnt + 4'd1;
                if (r_mcnt == 4'(ttf_pkg::M_B2_B)) begin
                    n_state = S_DIV;
                    n_didx  = '0;
                    n_dgo   = 1'b1;
                end
            end
            S_DIV: begin
                // wait for the last difference to be written before the first start
                if (r_dgo) begin
                    n_dgo = 1'b0;
                end else if (r_mcnt != 4'd0) begin
                    n_mcnt = 4'd0;
                    if (i_stat.det_zero) begin
                        n_state = S_EMIT;
                    end else begin
                        o_cmd.div_start = 1'b1;
                    end
                end else if (i_stat.div_done) begin
                    if (r_didx == 3'd5) begin
                        n_state = S_EMIT;
                    end else begin
                        n_didx = r_didx + 3'd1;
                        n_mcnt = 4'd1;
                    end
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 2'd0;
            r_mcnt  <= '0;
            r_didx  <= '0;
            r_dgo   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_mcnt  <= n_mcnt;
            r_didx  <= n_didx;
            r_dgo   <= n_dgo;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_phase = r_phase;
endmodule
`default_nettype wire

FILE: rtl/core/triangle_tangent_frame.sv
// top level: tangent and bitangent of textured triangles from a vertex stream
//  channel  | handshake        | payload
//  vertex   | start / busy     | i_vtx (ttf_pkg::t_in)
//  result   | o_valid strobe   | o_res (ttf_pkg::t_out)
// first and second vertex of a triangle are stored while the controller stays idle.
// third vertex: 14 products on the shared 32x32 multiplier, a wait for the last difference, then six
// quotients on one bit-serial divider, each a start, 80 steps and done.
// busy stays high from the third vertex through the emit state; when degenerate, no divide is run.
// synchronous active-low reset clears the phase and the controller.
// the result strobe lasts one cycle and cannot be stalled.
`default_nettype none
`include "triangle_tangent_frame_defines.svh"
module triangle_tangent_frame (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            start,
    output logic           busy,
    input  ttf_pkg::t_in   i_vtx,
    output logic           o_valid,
    output ttf_pkg::t_out  o_res
);
    ttf_pkg::t_cmd  w_cmd;
    ttf_pkg::t_stat w_stat;
    logic [1:0]     w_phase;
    logic           w_accept;

    assign w_accept = start && !busy;

    ttf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_last   (i_vtx.end_of_list),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_phase  (w_phase)
    );

    ttf_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vtx    (i_vtx),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_res    (o_res),
        .o_strobe (o_valid)
    );

    `TTF_ASSERT_IMPL(a_no_phase3, i_clk, i_rst_n, 1'b1, w_phase != 2'd3)
    `TTF_ASSERT_IMPL(a_valid_busy_done, i_clk, i_rst_n, o_valid, !$past(w_accept))
    `TTF_ASSERT_NEXT(a_third_busy, i_clk, i_rst_n, w_accept && w_phase == 2'd2, busy)
endmodule
`default_nettype wire

FILE: bench/tb_triangle_tangent_frame.sv
// testbench of the triangle tangent frame block: directed and random vertex streams
`timescale 1ns / 1ps
`default_nettype none
module tb_triangle_tangent_frame;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 1200;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    ttf_pkg::t_in   i_vtx;
    logic           o_valid;
    ttf_pkg::t_out  o_res;

    triangle_tangent_frame dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_vtx   (i_vtx),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    // tangent frame predictor state
    logic signed [31:0] frame_p0 [3];
    logic signed [31:0] frame_uv0 [2];
    logic signed [31:0] frame_p1 [3];
    logic signed [31:0] frame_uv1 [2];
    logic [1:0]         frame_phase;

    ttf_pkg::t_out frame_q [$];
    int   mismatch_cnt;
    int   idle_cycles;
    bit   no_gaps;
    bit   timed_out;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] delta32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        if (d > 33'sd2147483647) return 32'sh7fffffff;
        if (d < -33'sd2147483648) return 32'sh80000000;
        return d[31:0];
    endfunction

    function automatic logic signed [63:0] cross_diff(input logic signed [31:0] a,
                                                      input logic signed [31:0] b,
                                                      input logic signed [31:0] c,
                                                      input logic signed [31:0] d);
        logic signed [65:0] r;
        r = 66'(64'(a) * 64'(b)) - 66'(64'(c) * 64'(d));
        if (r > 66'sh0_7fff_ffff_ffff_ffff) return {1'b0, {63{1'b1}}};
        if (r < -66'sh0_8000_0000_0000_0000) return {1'b1, 63'd0};
        return r[63:0];
    endfunction

    // truncating (num << FRAC_BITS) / det, saturated to 32 bits
    function automatic logic signed [31:0] frame_quot(input logic signed [63:0] num,
                                                      input logic signed [63:0] det);
        logic [127:0] n_mag;
        logic [127:0] d_mag;
        logic [127:0] q;
        bit           neg;
        n_mag = num[63] ? 128'(-65'(num)) : 128'(num);
        d_mag = det[63] ? 128'(-65'(det)) : 128'(det);
        neg = num[63] != det[63];
        q = (n_mag << ttf_pkg::FRAC_BITS) / d_mag;
        if (neg) begin
            if (q > 128'h8000_0000) q = 128'h8000_0000;
            return -q[31:0];
        end
        if (q > 128'h7fff_ffff) q = 128'h7fff_ffff;
        return q[31:0];
    endfunction

    task automatic predict_frame(input ttf_pkg::t_in v);
        logic signed [31:0] p [3];
        logic signed [31:0] dp1 [3];
        logic signed [31:0] dp2 [3];
        logic signed [31:0] du1, dv1, du2, dv2;
        logic signed [63:0] det;
        logic signed [31:0] t [3];
        logic signed [31:0] b [3];
        ttf_pkg::t_out r;
        p[0] = v.pos_x; p[1] = v.pos_y; p[2] = v.pos_z;
        if (frame_phase == 2'd1) begin
            frame_p1 = p;
            frame_uv1[0] = v.tex_u;
            frame_uv1[1] = v.tex_v;
            frame_phase = 2'd2;
        end else if (frame_phase == 2'd2) begin
            for (int i = 0; i < 3; i++) begin
                dp1[i] = delta32(frame_p1[i], frame_p0[i]);
                dp2[i] = delta32(p[i], frame_p0[i]);
            end
            du1 = delta32(frame_uv1[0], frame_uv0[0]);
            dv1 = delta32(frame_uv1[1], frame_uv0[1]);
            du2 = delta32(v.tex_u, frame_uv0[0]);
            dv2 = delta32(v.tex_v, frame_uv0[1]);
            det = cross_diff(du1, dv2, dv1, du2);
            for (int i = 0; i < 3; i++) begin
                if (det == 0) begin
                    t[i] = '0;
                    b[i] = '0;
                end else begin
                    t[i] = frame_quot(cross_diff(dp1[i], dv2, dp2[i], dv1), det);
                    b[i] = frame_quot(cross_diff(dp2[i], du1, dp1[i], du2), det);
                end
            end
            r.tangent_x = t[0]; r.tangent_y = t[1]; r.tangent_z = t[2];
            r.bitangent_x = b[0]; r.bitangent_y = b[1]; r.bitangent_z = b[2];
            r.degenerate = (det == 0);
            frame_q.push_back(r);
            frame_phase = 2'd0;
        end else begin
            frame_p0 = p;
            frame_uv0[0] = v.tex_u;
            frame_uv0[1] = v.tex_v;
            frame_phase = 2'd1;
        end
        if (v.end_of_list) frame_phase = 2'd0;
    endtask

    // drives one vertex beat and waits for it to be taken
    task automatic send_vertex(input ttf_pkg::t_in v);
        if (!no_gaps) begin
            while ($urandom_range(99) < 9) begin
                start <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_vtx <= v;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_frame(v);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(1, 0) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
        endcase
    endfunction

    function automatic ttf_pkg::t_in rand_vertex(input bit last);
        ttf_pkg::t_in v;
        v.pos_x = rand_coord();
        v.pos_y = rand_coord();
        v.pos_z = rand_coord();
        v.tex_u = rand_coord();
        v.tex_v = rand_coord();
        v.end_of_list = last;
        return v;
    endfunction

    function automatic ttf_pkg::t_in mk_vertex(input int x, input int y, input int z,
                                               input int u, input int w, input bit last);
        ttf_pkg::t_in v;
        v.pos_x = x; v.pos_y = y; v.pos_z = z;
        v.tex_u = u; v.tex_v = w; v.end_of_list = last;
        return v;
    endfunction

    task automatic test_unit_triangle();
        send_vertex(mk_vertex(0, 0, 0, 0, 0, 1'b0));
        send_vertex(mk_vertex(32'h10000, 0, 0, 32'h10000, 0, 1'b0));
        send_vertex(mk_vertex(0, 32'h10000, 0, 0, 32'h10000, 1'b1));
    endtask

    task automatic test_degenerate_uv();
        send_vertex(mk_vertex(5, 6, 7, 32'h20000, 32'h20000, 1'b0));
        send_vertex(mk_vertex(8, 9, 10, 32'h20000, 32'h20000, 1'b0));
        send_vertex(mk_vertex(1, 2, 3, 32'h20000, 32'h20000, 1'b0));
    endtask

    task automatic test_field_extremes();
        send_vertex(mk_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                              32'h8000_0000, 32'h7fff_ffff, 1'b0));
        send_vertex(mk_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                              32'h7fff_ffff, 32'h8000_0000, 1'b0));
        send_vertex(mk_vertex(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                              32'h7fff_ffff, 32'h7fff_ffff, 1'b0));
        // tiny det, large numerators: quotient saturates
        send_vertex(mk_vertex(0, 0, 0, 0, 0, 1'b0));
        send_vertex(mk_vertex(32'h7fff_0000, 32'h8000_0000, 1, 1, 0, 1'b0));
        send_vertex(mk_vertex(32'h8000_0000, 32'h7fff_0000, -1, 0, 1, 1'b0));
        send_vertex(mk_vertex(-1, -1, -1, -1, -1, 1'b0));
        send_vertex(mk_vertex(0, 0, 0, 0, 0, 1'b0));
        send_vertex(mk_vertex(1, 1, 1, 32'h10000, -32'h30000, 1'b0));
    endtask

    task automatic test_end_of_list();
        // list ends after one vertex, then after two: no results
        send_vertex(mk_vertex(11, 12, 13, 14, 15, 1'b1));
        send_vertex(mk_vertex(1, 2, 3, 4, 5, 1'b0));
        send_vertex(mk_vertex(6, 7, 8, 9, 10, 1'b1));
        test_unit_triangle();
    endtask

    task automatic test_random_stream(input int n_items);
        int left;
        int len;
        left = n_items;
        while (left > 0) begin
            // lists starting in the first hundred beats run without gaps, as does about one list in ten later on
            no_gaps = (left > n_items - 100) || ($urandom_range(9) == 0);
            // mostly whole triangles, sometimes a list cut short
            len = ($urandom_range(9) < 8) ? 3 * $urandom_range(1, 4)
                                           : $urandom_range(1, 5);
            for (int i = 0; i < len && left > 0; i++) begin
                send_vertex(rand_vertex(i == len - 1 && $urandom_range(1, 0)));
                left--;
            end
        end
        no_gaps = 1'b0;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (frame_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected result beat %p", o_res);
            end else if (o_res !== frame_q[0]) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("result mismatch: expected %p actual %p", frame_q[0], o_res);
                void'(frame_q.pop_front());
            end else begin
                void'(frame_q.pop_front());
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                timed_out = 1'b1;
                $display("triangle_tangent_frame verification failed");
                $finish;
            end
        end
    end

    initial begin
        int drain;
        start = 1'b0;
        i_vtx = '0;
        i_rst_n = 1'b0;
        mismatch_cnt = 0;
        idle_cycles = 0;
        no_gaps = 1'b0;
        timed_out = 1'b0;
        frame_phase = 2'd0;
        for (int i = 0; i < 3; i++) begin
            frame_p0[i] = '0;
            frame_p1[i] = '0;
        end
        for (int i = 0; i < 2; i++) begin
            frame_uv0[i] = '0;
            frame_uv1[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_unit_triangle();
        test_degenerate_uv();
        test_field_extremes();
        test_end_of_list();
        test_random_stream(640);
        start <= 1'b0;

        drain = 0;
        while (frame_q.size() != 0 && drain < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && frame_q.size() == 0) begin
            $display("triangle_tangent_frame verification clean");
        end else begin
            $display("triangle_tangent_frame verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
